// ===== rtl/max_min_d_cluster_election_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cluster election block.
// Each macro expects signals named clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_D_CLUSTER_ELECTION_TOP_DEFINES_SVH
`define MAX_MIN_D_CLUSTER_ELECTION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MCDE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define MCDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCDE_ASSERT_IMPL(label, ante, cons)
`define MCDE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/mcde_pkg.sv =====
// ----------------------------------------------------------------------------
// mcde_pkg
// Shared types and constants of the cluster election block.
// ----------------------------------------------------------------------------
package mcde_pkg;

  localparam int ADDR_W = 48;
  localparam int ID_W   = 32;
  localparam int HOPS_W = 5;
  localparam int RND_W  = 4;
  localparam int DIST_W = 5;
  localparam int WARM_W = 8;
  localparam int FLD_W  = 8;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OWN_ADDR = 2'd0;
  localparam logic [1:0] REG_OWN_ID   = 2'd1;
  localparam logic [1:0] REG_DIST     = 2'd2;
  localparam logic [1:0] REG_WARMUP   = 2'd3;

  // Reset values of the registers.
  localparam logic [DIST_W-1:0] DIST_RESET   = 5'd2;
  localparam logic [WARM_W-1:0] WARMUP_RESET = 8'd12;

  // Item operations.
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] own_addr;
    logic [ID_W-1:0]   own_id;
    logic [DIST_W-1:0] cl_dist;
    logic [WARM_W-1:0] warm;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic [HOPS_W-1:0] hops;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/mcde_ram.sv =====
// ----------------------------------------------------------------------------
// mcde_ram
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module mcde_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 85
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mcde_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcde_ctrl
// Sequencer that merges probes into the round tables, builds outgoing
// advertisements and walks the tables to elect the cluster head.
// ----------------------------------------------------------------------------
`include "max_min_d_cluster_election_top_defines.svh"
module mcde_ctrl #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mcde_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [mcde_pkg::ADDR_W-1:0]  in_max_address,
  input  logic [mcde_pkg::ID_W-1:0]    in_max_node_id,
  input  logic [mcde_pkg::FLD_W-1:0]   in_max_hops,
  input  logic [mcde_pkg::FLD_W-1:0]   in_max_round_index,
  input  logic [mcde_pkg::ADDR_W-1:0]  in_min_address,
  input  logic [mcde_pkg::ID_W-1:0]    in_min_node_id,
  input  logic [mcde_pkg::FLD_W-1:0]   in_min_hops,
  input  logic [mcde_pkg::FLD_W-1:0]   in_min_round_index,
  input  logic                         in_min_present,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mcde_pkg::ADDR_W-1:0]  out_max_address,
  output logic [mcde_pkg::ID_W-1:0]    out_max_id,
  output logic [mcde_pkg::HOPS_W-1:0]  out_max_hops,
  output logic [mcde_pkg::RND_W-1:0]   out_max_round,
  output logic [mcde_pkg::ADDR_W-1:0]  out_min_address,
  output logic [mcde_pkg::ID_W-1:0]    out_min_id,
  output logic [mcde_pkg::HOPS_W-1:0]  out_min_hops,
  output logic [mcde_pkg::RND_W-1:0]   out_min_round,
  output logic                         out_min_present,
  output logic [mcde_pkg::ADDR_W-1:0]  out_head_address,
  output logic [mcde_pkg::ID_W-1:0]    out_head_id
);

  localparam int IW  = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int LIM = (MAX_ROUNDS < 16) ? MAX_ROUNDS : 16;
  localparam logic [mcde_pkg::DIST_W-1:0] LIM_D = mcde_pkg::DIST_W'(LIM);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_MRG   = 6'b000100,
    S_SND1  = 6'b001000,
    S_SND2  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // Election walk runs as a flag inside the output-free part of the sequence.
  typedef enum logic [1:0] {
    W_OFF  = 2'b01,
    W_WALK = 2'b10
  } walk_t;

  function automatic logic [IW-1:0] to_idx(input logic [7:0] v);
    return v[IW-1:0];
  endfunction

  state_t state_r, state_nxt;
  walk_t  walk_r;

  // Latched item.
  logic                         op_r;
  mcde_pkg::entry_t             xin_r, nin_r;
  logic [mcde_pkg::FLD_W-1:0]   xh_r, xr_r, nh_r, nr_r;
  logic                         np_r;

  // Round bookkeeping.
  logic [mcde_pkg::RND_W-1:0]   nmax_r, nmin_r;
  logic [mcde_pkg::DIST_W-1:0]  mcnt_r, ncnt_r;
  logic [mcde_pkg::WARM_W-1:0]  warm_cnt_r;
  logic [mcde_pkg::RND_W-1:0]   r_r, m_r;
  logic                         warm_act_r;
  logic [MAX_ROUNDS-1:0]        vmax_r, vmin_r;

  // Head.
  logic                         head_self_r;
  logic [mcde_pkg::ADDR_W-1:0]  head_addr_r;
  logic [mcde_pkg::ID_W-1:0]    head_id_r;

  // Staged result.
  mcde_pkg::entry_t             rmax_r, rmin_r;
  logic [mcde_pkg::RND_W-1:0]   rmax_rnd_r, rmin_rnd_r;
  logic                         rmin_pres_r;

  // Election walk.
  logic [mcde_pkg::DIST_W-1:0]  ei_r, ej_r, pi_r, pj_r;
  logic                         iss_done_r, p_vld_r;
  logic                         r1_r, b2_r, b3_r;
  logic [mcde_pkg::ADDR_W-1:0]  b2_addr_r, b3_addr_r;
  logic [mcde_pkg::ID_W-1:0]    b2_id_r, b3_id_r;

  // Output register.
  logic                         out_valid_r;
  mcde_pkg::entry_t             omax_r, omin_r;
  logic [mcde_pkg::RND_W-1:0]   omax_rnd_r, omin_rnd_r;
  logic                         omin_pres_r;
  logic [mcde_pkg::ADDR_W-1:0]  ohead_addr_r;
  logic [mcde_pkg::ID_W-1:0]    ohead_id_r;

  // Memory ports.
  logic                         max_we, min_we, max_re, min_re;
  logic [IW-1:0]                max_waddr, min_waddr, max_raddr, min_raddr;
  mcde_pkg::entry_t             max_wdata, min_wdata, max_rd, min_rd;

  // Derived values.
  logic [mcde_pkg::DIST_W-1:0]  d_w, mc_w, nc_w;
  logic                         accept, out_load, walk_end;
  logic [mcde_pkg::RND_W-1:0]   r_w, m_w;
  logic                         max_ok, min_ok;
  logic [8:0]                   xh1, nh1;
  logic [mcde_pkg::DIST_W-1:0]  mc_new, nc_new;

  // Effective distance and clamped round counts.
  always_comb begin
    if (cfg.cl_dist == '0) d_w = mcde_pkg::DIST_W'(1);
    else if (cfg.cl_dist > LIM_D) d_w = LIM_D;
    else d_w = cfg.cl_dist;
    if (mcnt_r == '0) mc_w = mcde_pkg::DIST_W'(1);
    else if (mcnt_r > d_w) mc_w = d_w;
    else mc_w = mcnt_r;
    if (ncnt_r == '0) nc_w = mcde_pkg::DIST_W'(1);
    else if (ncnt_r > d_w) nc_w = d_w;
    else nc_w = ncnt_r;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_OUT) && (walk_r == W_OFF) && (!out_valid_r || !out_stall);
  assign walk_end = (walk_r == W_WALK) && iss_done_r && !p_vld_r;

  // Send rounds for this beat.
  assign r_w = ({1'b0, nmax_r} >= mc_w) ? '0 : nmax_r;
  assign m_w = ({1'b0, nmin_r} >= nc_w) ? '0 : nmin_r;

  // Merge decisions.
  assign xh1 = {1'b0, xh_r} + 9'd1;
  assign nh1 = {1'b0, nh_r} + 9'd1;
  always_comb begin
    max_ok = (xh_r < {3'b0, d_w}) && (xr_r < {3'b0, d_w}) &&
             (!vmax_r[to_idx(xr_r)] || (xin_r.id > max_rd.id) ||
              ((xin_r.id == max_rd.id) && (xh1 < {4'b0, max_rd.hops})));
    min_ok = np_r && (nr_r < {3'b0, d_w}) &&
             (!vmin_r[to_idx(nr_r)] || (nin_r.id < min_rd.id) ||
              ((nin_r.id == min_rd.id) && (nh1 < {4'b0, min_rd.hops})));
    mc_new = mc_w;
    if (max_ok && ({3'b0, mc_w} == (xr_r + 8'd1)) && (mc_w < d_w)) begin
      mc_new = mc_w + mcde_pkg::DIST_W'(1);
    end
    nc_new = nc_w;
    if (min_ok && ({3'b0, nc_w} == (nr_r + 8'd1)) && (nc_w < d_w)) begin
      nc_new = nc_w + mcde_pkg::DIST_W'(1);
    end
  end

  // Memory write data and enables.
  always_comb begin
    max_we    = (state_r == S_MRG) && max_ok;
    min_we    = (state_r == S_MRG) && min_ok;
    max_waddr = to_idx(xr_r);
    min_waddr = to_idx(nr_r);
    max_wdata = '{addr: xin_r.addr, id: xin_r.id, hops: xh1[mcde_pkg::HOPS_W-1:0]};
    min_wdata = '{addr: nin_r.addr, id: nin_r.id,
                  hops: (nh1 > 9'd16) ? mcde_pkg::HOPS_W'(16) : nh1[mcde_pkg::HOPS_W-1:0]};
  end

  // Memory read addresses by phase.
  always_comb begin
    max_re    = 1'b0;
    min_re    = 1'b0;
    max_raddr = to_idx(xr_r);
    min_raddr = to_idx(nr_r);
    if (walk_r == W_WALK) begin
      max_re    = !iss_done_r;
      min_re    = !iss_done_r;
      max_raddr = to_idx(8'(ej_r));
      min_raddr = to_idx(8'(ei_r));
    end else begin
      case (state_r)
        S_ISSUE: begin
          max_re = 1'b1;
          min_re = 1'b1;
          if (op_r == mcde_pkg::OP_SEND) begin
            max_raddr = to_idx(8'(r_r) - 8'd1);
            min_raddr = to_idx(8'(m_r) - 8'd1);
          end
        end
        S_SND1: begin
          max_re    = 1'b1;
          max_raddr = to_idx(8'(d_w) - 8'd1);
        end
        default: begin
          max_re = 1'b0;
        end
      endcase
    end
  end

  mcde_ram #(.DEPTH(MAX_ROUNDS), .AW(IW), .WIDTH(mcde_pkg::ENTRY_W)) u_max_ram (
    .clk(clk), .we(max_we), .waddr(max_waddr), .wdata(max_wdata),
    .re(max_re), .raddr(max_raddr), .rdata(max_rd)
  );

  mcde_ram #(.DEPTH(MAX_ROUNDS), .AW(IW), .WIDTH(mcde_pkg::ENTRY_W)) u_min_ram (
    .clk(clk), .we(min_we), .waddr(min_waddr), .wdata(min_wdata),
    .re(min_re), .raddr(min_raddr), .rdata(min_rd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = (op_r == mcde_pkg::OP_RECV) ? S_MRG : S_SND1;
      S_MRG:   state_nxt = S_OUT;
      S_SND1:  state_nxt = (warm_act_r && (m_r == '0)) ? S_SND2 : S_OUT;
      S_SND2:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= W_OFF;
      nmax_r      <= '0;
      nmin_r      <= '0;
      mcnt_r      <= mcde_pkg::DIST_W'(1);
      ncnt_r      <= mcde_pkg::DIST_W'(1);
      warm_cnt_r  <= '0;
      vmax_r      <= '0;
      vmin_r      <= '0;
      head_self_r <= 1'b1;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      iss_done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Send bookkeeping happens on the accepted beat.
      if (accept && (in_op == mcde_pkg::OP_SEND)) begin
        nmax_r <= ({1'b0, r_w} + 5'd1 == mc_w) ? '0 : r_w + 4'd1;
        if (warm_cnt_r > cfg.warm) begin
          nmin_r <= ({1'b0, m_w} + 5'd1 == nc_w) ? '0 : m_w + 4'd1;
        end else if (warm_cnt_r != 8'hFF) begin
          warm_cnt_r <= warm_cnt_r + 8'd1;
        end
      end

      // Merge commits the table entries and round counts.
      if (state_r == S_MRG) begin
        if (max_ok) vmax_r[to_idx(xr_r)] <= 1'b1;
        if (min_ok) vmin_r[to_idx(nr_r)] <= 1'b1;
        mcnt_r <= mc_new;
        ncnt_r <= nc_new;
        if (nc_new == d_w) begin
          walk_r     <= W_WALK;
          iss_done_r <= 1'b0;
          p_vld_r    <= 1'b0;
        end
      end

      // Election walk: issue one pair a cycle, check it the next.
      if (walk_r == W_WALK) begin
        p_vld_r <= !iss_done_r;
        if (!iss_done_r && (ei_r == d_w - 5'd1) && (ej_r == d_w - 5'd1)) begin
          iss_done_r <= 1'b1;
        end
        if (walk_end) begin
          walk_r <= W_OFF;
          head_self_r <= r1_r || (!b2_r && !b3_r);
        end
      end

      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_op;
      xin_r.addr <= in_max_address;
      xin_r.id   <= in_max_node_id;
      xin_r.hops <= '0;
      nin_r.addr <= in_min_address;
      nin_r.id   <= in_min_node_id;
      nin_r.hops <= '0;
      xh_r       <= in_max_hops;
      xr_r       <= in_max_round_index;
      nh_r       <= in_min_hops;
      nr_r       <= in_min_round_index;
      np_r       <= in_min_present;
      r_r        <= r_w;
      m_r        <= m_w;
      warm_act_r <= warm_cnt_r > cfg.warm;
    end

    // Receive results carry zero advertisements.
    if (state_r == S_MRG) begin
      rmax_r      <= '0;
      rmin_r      <= '0;
      rmax_rnd_r  <= '0;
      rmin_rnd_r  <= '0;
      rmin_pres_r <= 1'b0;
      ei_r        <= '0;
      ej_r        <= '0;
      r1_r        <= 1'b0;
      b2_r        <= 1'b0;
      b3_r        <= 1'b0;
    end

    // Send: max part and the min part from the min table or the node itself.
    if (state_r == S_SND1) begin
      rmax_rnd_r <= r_r;
      if ((r_r != '0) && vmax_r[to_idx(8'(r_r) - 8'd1)]) begin
        rmax_r <= max_rd;
      end else begin
        rmax_r <= '{addr: cfg.own_addr, id: cfg.own_id, hops: '0};
      end
      rmin_rnd_r <= warm_act_r ? m_r : '0;
      if (warm_act_r && (m_r != '0) && vmin_r[to_idx(8'(m_r) - 8'd1)]) begin
        rmin_r      <= min_rd;
        rmin_pres_r <= 1'b1;
      end else begin
        rmin_r      <= '{addr: cfg.own_addr, id: cfg.own_id, hops: '0};
        rmin_pres_r <= 1'b0;
      end
    end

    // Send, min round zero: advertise the farthest max round.
    if ((state_r == S_SND2) && vmax_r[to_idx(8'(d_w) - 8'd1)]) begin
      rmin_r      <= max_rd;
      rmin_pres_r <= 1'b1;
    end

    // Election issue counters, min outer and max inner.
    if ((walk_r == W_WALK) && !iss_done_r) begin
      pi_r <= ei_r;
      pj_r <= ej_r;
      if (ej_r == d_w - 5'd1) begin
        ej_r <= '0;
        ei_r <= ei_r + 5'd1;
      end else begin
        ej_r <= ej_r + 5'd1;
      end
    end

    // Election checks on the pair that arrived.
    if ((walk_r == W_WALK) && p_vld_r) begin
      if ((pj_r == '0) && vmin_r[to_idx(8'(pi_r))] && (min_rd.id == cfg.own_id)) begin
        r1_r <= 1'b1;
      end
      if (vmin_r[to_idx(8'(pi_r))] && vmax_r[to_idx(8'(pj_r))] &&
          (min_rd.id == max_rd.id) && (!b2_r || (min_rd.id < b2_id_r))) begin
        b2_r      <= 1'b1;
        b2_addr_r <= min_rd.addr;
        b2_id_r   <= min_rd.id;
      end
      if ((pi_r == '0) && vmax_r[to_idx(8'(pj_r))] && (!b3_r || (max_rd.id > b3_id_r))) begin
        b3_r      <= 1'b1;
        b3_addr_r <= max_rd.addr;
        b3_id_r   <= max_rd.id;
      end
    end

    // Head decision at the end of the walk.
    if (walk_end && !r1_r) begin
      head_addr_r <= b2_r ? b2_addr_r : b3_addr_r;
      head_id_r   <= b2_r ? b2_id_r : b3_id_r;
    end

    // Output register.
    if (out_load) begin
      omax_r       <= rmax_r;
      omin_r       <= rmin_r;
      omax_rnd_r   <= rmax_rnd_r;
      omin_rnd_r   <= rmin_rnd_r;
      omin_pres_r  <= rmin_pres_r;
      ohead_addr_r <= head_self_r ? cfg.own_addr : head_addr_r;
      ohead_id_r   <= head_self_r ? cfg.own_id : head_id_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_max_address  = omax_r.addr;
  assign out_max_id       = omax_r.id;
  assign out_max_hops     = omax_r.hops;
  assign out_max_round    = omax_rnd_r;
  assign out_min_address  = omin_r.addr;
  assign out_min_id       = omin_r.id;
  assign out_min_hops     = omin_r.hops;
  assign out_min_round    = omin_rnd_r;
  assign out_min_present  = omin_pres_r;
  assign out_head_address = ohead_addr_r;
  assign out_head_id      = ohead_id_r;

  // A finished result always lands in the output register.
  `MCDE_ASSERT_NEXT(a_out_load, out_load, out_valid_r)
  // The walk hands over to the output stage once the last pair is checked.
  `MCDE_ASSERT_NEXT(a_walk_end, walk_end, (walk_r == W_OFF) && (state_r == S_OUT))
  // Valid bits move only on a merge.
  `MCDE_ASSERT_NEXT(a_valid_hold, state_r != S_MRG, $stable(vmax_r) && $stable(vmin_r))
  // No new item is taken while the walk runs.
  `MCDE_ASSERT_IMPL(a_walk_busy, walk_r == W_WALK, in_stall)

endmodule

// ===== rtl/max_min_d_cluster_election_top.sv =====
// ----------------------------------------------------------------------------
// max_min_d_cluster_election_top
// Max-Min d-hop cluster election engine with its register port.
// ----------------------------------------------------------------------------
// One item is handled at a time. A send beat passes the issue and send states,
// and a second send state when the farthest max round is advertised as min
// round zero. A receive beat passes the issue and merge states, and an election
// runs when the min rounds are full, D being the effective cluster distance:
// the election reads one min/max entry pair per cycle from the two table
// memories, D*D pairs in all. A new item is accepted while the previous
// result still waits in the output register.
// Registers sit at byte addresses 0, 8, 16 and 24 with 64-bit data.
module max_min_d_cluster_election_top #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [mcde_pkg::ADDR_W-1:0]  in_max_address,
  input  logic [mcde_pkg::ID_W-1:0]    in_max_node_id,
  input  logic [mcde_pkg::FLD_W-1:0]   in_max_hops,
  input  logic [mcde_pkg::FLD_W-1:0]   in_max_round_index,
  input  logic [mcde_pkg::ADDR_W-1:0]  in_min_address,
  input  logic [mcde_pkg::ID_W-1:0]    in_min_node_id,
  input  logic [mcde_pkg::FLD_W-1:0]   in_min_hops,
  input  logic [mcde_pkg::FLD_W-1:0]   in_min_round_index,
  input  logic                         in_min_present,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mcde_pkg::ADDR_W-1:0]  out_max_address,
  output logic [mcde_pkg::ID_W-1:0]    out_max_id,
  output logic [mcde_pkg::HOPS_W-1:0]  out_max_hops,
  output logic [mcde_pkg::RND_W-1:0]   out_max_round,
  output logic [mcde_pkg::ADDR_W-1:0]  out_min_address,
  output logic [mcde_pkg::ID_W-1:0]    out_min_id,
  output logic [mcde_pkg::HOPS_W-1:0]  out_min_hops,
  output logic [mcde_pkg::RND_W-1:0]   out_min_round,
  output logic                         out_min_present,
  output logic [mcde_pkg::ADDR_W-1:0]  out_head_address,
  output logic [mcde_pkg::ID_W-1:0]    out_head_id
);

  mcde_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_addr <= '0;
      cfg_r.own_id   <= '0;
      cfg_r.cl_dist  <= mcde_pkg::DIST_RESET;
      cfg_r.warm     <= mcde_pkg::WARMUP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        mcde_pkg::REG_OWN_ADDR: cfg_r.own_addr <= pwdata[mcde_pkg::ADDR_W-1:0];
        mcde_pkg::REG_OWN_ID:   cfg_r.own_id   <= pwdata[mcde_pkg::ID_W-1:0];
        mcde_pkg::REG_DIST:     cfg_r.cl_dist  <= pwdata[mcde_pkg::DIST_W-1:0];
        mcde_pkg::REG_WARMUP:   cfg_r.warm     <= pwdata[mcde_pkg::WARM_W-1:0];
        default:                cfg_r.warm     <= cfg_r.warm;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      mcde_pkg::REG_OWN_ADDR: prdata = 64'(cfg_r.own_addr);
      mcde_pkg::REG_OWN_ID:   prdata = 64'(cfg_r.own_id);
      mcde_pkg::REG_DIST:     prdata = 64'(cfg_r.cl_dist);
      mcde_pkg::REG_WARMUP:   prdata = 64'(cfg_r.warm);
      default:                prdata = '0;
    endcase
  end

  mcde_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_max_address     (in_max_address),
    .in_max_node_id     (in_max_node_id),
    .in_max_hops        (in_max_hops),
    .in_max_round_index (in_max_round_index),
    .in_min_address     (in_min_address),
    .in_min_node_id     (in_min_node_id),
    .in_min_hops        (in_min_hops),
    .in_min_round_index (in_min_round_index),
    .in_min_present     (in_min_present),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_max_address    (out_max_address),
    .out_max_id         (out_max_id),
    .out_max_hops       (out_max_hops),
    .out_max_round      (out_max_round),
    .out_min_address    (out_min_address),
    .out_min_id         (out_min_id),
    .out_min_hops       (out_min_hops),
    .out_min_round      (out_min_round),
    .out_min_present    (out_min_present),
    .out_head_address   (out_head_address),
    .out_head_id        (out_head_id)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cluster election block testbench
// Drives send and receive probes into the election block and checks every
// result beat against a cycle-free model of the round tables, the warm-up
// counter and the head election. Both channels idle and stall at random,
// and the register settings are changed between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 300;
  localparam int NROUND         = 16;

  typedef struct {
    logic                        op;
    logic [mcde_pkg::ADDR_W-1:0] max_addr;
    logic [mcde_pkg::ID_W-1:0]   max_id;
    logic [7:0]                  max_hops;
    logic [7:0]                  max_rnd;
    logic [mcde_pkg::ADDR_W-1:0] min_addr;
    logic [mcde_pkg::ID_W-1:0]   min_id;
    logic [7:0]                  min_hops;
    logic [7:0]                  min_rnd;
    logic                        min_pres;
  } probe_t;

  typedef struct {
    logic [mcde_pkg::ADDR_W-1:0] max_addr;
    logic [mcde_pkg::ID_W-1:0]   max_id;
    logic [4:0]                  max_hops;
    logic [3:0]                  max_rnd;
    logic [mcde_pkg::ADDR_W-1:0] min_addr;
    logic [mcde_pkg::ID_W-1:0]   min_id;
    logic [4:0]                  min_hops;
    logic [3:0]                  min_rnd;
    logic                        min_pres;
    logic [mcde_pkg::ADDR_W-1:0] head_addr;
    logic [mcde_pkg::ID_W-1:0]   head_id;
  } advert_t;

  typedef struct {
    logic [mcde_pkg::ADDR_W-1:0] addr;
    logic [mcde_pkg::ID_W-1:0]   id;
    int unsigned                 hops;
    bit                          valid;
  } round_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [mcde_pkg::ADDR_W-1:0] in_max_address = '0;
  logic [mcde_pkg::ID_W-1:0] in_max_node_id = '0;
  logic [mcde_pkg::FLD_W-1:0] in_max_hops = '0;
  logic [mcde_pkg::FLD_W-1:0] in_max_round_index = '0;
  logic [mcde_pkg::ADDR_W-1:0] in_min_address = '0;
  logic [mcde_pkg::ID_W-1:0] in_min_node_id = '0;
  logic [mcde_pkg::FLD_W-1:0] in_min_hops = '0;
  logic [mcde_pkg::FLD_W-1:0] in_min_round_index = '0;
  logic in_min_present = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mcde_pkg::ADDR_W-1:0] out_max_address;
  logic [mcde_pkg::ID_W-1:0] out_max_id;
  logic [mcde_pkg::HOPS_W-1:0] out_max_hops;
  logic [mcde_pkg::RND_W-1:0] out_max_round;
  logic [mcde_pkg::ADDR_W-1:0] out_min_address;
  logic [mcde_pkg::ID_W-1:0] out_min_id;
  logic [mcde_pkg::HOPS_W-1:0] out_min_hops;
  logic [mcde_pkg::RND_W-1:0] out_min_round;
  logic out_min_present;
  logic [mcde_pkg::ADDR_W-1:0] out_head_address;
  logic [mcde_pkg::ID_W-1:0] out_head_id;

  max_min_d_cluster_election_top i_dut (.*);

  // Model state: registers, round tables and election result.
  logic [mcde_pkg::ADDR_W-1:0] own_addr_q;
  logic [mcde_pkg::ID_W-1:0]   own_id_q;
  logic [4:0]                  dist_q;
  logic [7:0]                  warm_q;
  round_entry_t max_rounds[NROUND];
  round_entry_t min_rounds[NROUND];
  int unsigned next_max_rnd, next_min_rnd, max_cnt, min_cnt, probes_sent;
  bit head_self;
  logic [mcde_pkg::ADDR_W-1:0] head_addr_q;
  logic [mcde_pkg::ID_W-1:0]   head_id_q;

  advert_t pending_adverts[$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_req = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned cur_dist();
    if (dist_q < 1) return 1;
    if (dist_q > NROUND) return NROUND;
    return 32'(dist_q);
  endfunction

  function automatic int unsigned clamp_cnt(int unsigned c, int unsigned d);
    if (c < 1) return 1;
    return (c > d) ? d : c;
  endfunction

  // Rule 1 picks the node itself, rule 2 the smallest id seen in both tables,
  // rule 3 the largest max id.
  function automatic void run_election(int unsigned d);
    int best;
    logic [mcde_pkg::ID_W-1:0] best_id;
    best = -1;
    best_id = '0;
    for (int i = 0; i < d; i++)
      if (min_rounds[i].valid && min_rounds[i].id == own_id_q) begin
        head_self = 1'b1;
        return;
      end
    for (int i = 0; i < d; i++) begin
      if (!min_rounds[i].valid) continue;
      for (int j = 0; j < d; j++)
        if (max_rounds[j].valid && max_rounds[j].id == min_rounds[i].id &&
            (best < 0 || min_rounds[i].id < best_id)) begin
          best = i;
          best_id = min_rounds[i].id;
        end
    end
    if (best >= 0) begin
      head_self = 1'b0;
      head_addr_q = min_rounds[best].addr;
      head_id_q = min_rounds[best].id;
      return;
    end
    for (int i = 0; i < d; i++)
      if (max_rounds[i].valid && (best < 0 || max_rounds[i].id > best_id)) begin
        best = i;
        best_id = max_rounds[i].id;
      end
    if (best >= 0) begin
      head_self = 1'b0;
      head_addr_q = max_rounds[best].addr;
      head_id_q = max_rounds[best].id;
    end else begin
      head_self = 1'b1;
    end
  endfunction

  // Works out the result beat of one accepted probe and updates the state.
  function automatic advert_t predict_election(probe_t p);
    advert_t a;
    round_entry_t e;
    int unsigned d, mc, nc, r;
    d = cur_dist();
    mc = clamp_cnt(max_cnt, d);
    nc = clamp_cnt(min_cnt, d);
    a = '{default: '0};
    if (p.op == mcde_pkg::OP_SEND) begin
      r = (next_max_rnd >= mc) ? 0 : next_max_rnd;
      a.max_addr = own_addr_q;
      a.max_id = own_id_q;
      a.max_rnd = 4'(r);
      if (r > 0 && max_rounds[r-1].valid) begin
        a.max_addr = max_rounds[r-1].addr;
        a.max_id = max_rounds[r-1].id;
        a.max_hops = 5'(max_rounds[r-1].hops);
      end
      next_max_rnd = (r + 1) % mc;
      a.min_addr = own_addr_q;
      a.min_id = own_id_q;
      if (probes_sent > warm_q) begin
        r = (next_min_rnd >= nc) ? 0 : next_min_rnd;
        e = (r == 0) ? max_rounds[d-1] : min_rounds[r-1];
        a.min_rnd = 4'(r);
        if (e.valid) begin
          a.min_addr = e.addr;
          a.min_id = e.id;
          a.min_hops = 5'(e.hops);
          a.min_pres = 1'b1;
        end
        next_min_rnd = (r + 1) % nc;
      end else if (probes_sent < 255) begin
        probes_sent++;
      end
    end else begin
      if (p.max_hops < d && p.max_rnd < d) begin
        e = max_rounds[p.max_rnd];
        if (!e.valid || p.max_id > e.id || (p.max_id == e.id && p.max_hops + 1 < e.hops)) begin
          max_rounds[p.max_rnd] = '{p.max_addr, p.max_id, p.max_hops + 1, 1'b1};
          if (mc == p.max_rnd + 1 && mc < d) mc++;
        end
      end
      if (p.min_pres && p.min_rnd < d) begin
        e = min_rounds[p.min_rnd];
        if (!e.valid || p.min_id < e.id || (p.min_id == e.id && p.min_hops + 1 < e.hops)) begin
          min_rounds[p.min_rnd] = '{p.min_addr, p.min_id,
                                    (p.min_hops + 1 > 16) ? 16 : p.min_hops + 1, 1'b1};
          if (nc == p.min_rnd + 1 && nc < d) nc++;
        end
      end
      max_cnt = mc;
      min_cnt = nc;
      if (nc == d) run_election(d);
    end
    a.head_addr = head_self ? own_addr_q : head_addr_q;
    a.head_id = head_self ? own_id_q : head_id_q;
    return a;
  endfunction

  // Offers one probe, waits for its beat, and optionally idles afterwards.
  task automatic send_probe(probe_t p);
    in_valid <= 1'b1;
    in_op <= p.op;
    in_max_address <= p.max_addr;
    in_max_node_id <= p.max_id;
    in_max_hops <= p.max_hops;
    in_max_round_index <= p.max_rnd;
    in_min_address <= p.min_addr;
    in_min_node_id <= p.min_id;
    in_min_hops <= p.min_hops;
    in_min_round_index <= p.min_rnd;
    in_min_present <= p.min_pres;
    do @(posedge clk); while (in_stall);
    pending_adverts.push_back(predict_election(p));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Withdraws the input, waits until every result beat is in, then lets the
  // block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_adverts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mcde_pkg::REG_OWN_ADDR: own_addr_q = val[mcde_pkg::ADDR_W-1:0];
      mcde_pkg::REG_OWN_ID:   own_id_q = val[mcde_pkg::ID_W-1:0];
      mcde_pkg::REG_DIST:     dist_q = val[4:0];
      mcde_pkg::REG_WARMUP:   warm_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [47:0] addr, logic [31:0] id, logic [4:0] d, logic [7:0] w);
    drain();
    write_reg(mcde_pkg::REG_OWN_ADDR, {16'h0, addr});
    write_reg(mcde_pkg::REG_OWN_ID, {32'h0, id});
    write_reg(mcde_pkg::REG_DIST, {59'h0, d});
    write_reg(mcde_pkg::REG_WARMUP, {56'h0, w});
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic probe_t send_item();
    probe_t p;
    p = '{default: '0};
    p.op = mcde_pkg::OP_SEND;
    return p;
  endfunction

  // Ids come mostly from a small pool so that ties and cross-table matches occur.
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 7))
      0: return own_id_q;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0;
      7: return $urandom;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic probe_t random_item();
    probe_t p;
    int unsigned d;
    d = cur_dist();
    p.op = ($urandom_range(0, 2) == 0) ? mcde_pkg::OP_SEND : mcde_pkg::OP_RECV;
    p.max_addr = rand48();
    p.min_addr = rand48();
    if ($urandom_range(0, 9) == 0) begin
      // Noise: any value of any field.
      p.max_id = $urandom;
      p.min_id = $urandom;
      p.max_hops = 8'($urandom);
      p.max_rnd = 8'($urandom);
      p.min_hops = 8'($urandom);
      p.min_rnd = 8'($urandom);
      p.min_pres = 1'($urandom);
    end else begin
      p.max_id = pick_id();
      p.min_id = pick_id();
      p.max_hops = 8'($urandom_range(0, d - 1));
      p.max_rnd = 8'($urandom_range(0, d - 1));
      p.min_hops = 8'($urandom_range(0, d));
      p.min_rnd = 8'($urandom_range(0, d - 1));
      p.min_pres = ($urandom_range(0, 7) != 0);
    end
    return p;
  endfunction

  task automatic test_directed();
    probe_t p;
    // Warm-up sends at the reset settings, then receives with field extremes.
    repeat (3) send_probe(send_item());
    p = '{mcde_pkg::OP_RECV, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 8'd0,
          48'hFFFF_FFFF_FFFF, 32'h0, 8'd0, 8'd0, 1'b1};
    send_probe(p);
    p = '{mcde_pkg::OP_RECV, 48'h1, 32'h5, 8'd255, 8'd255, 48'h2, 32'h7, 8'd255, 8'd255,
          1'b1};
    send_probe(p);
    p = '{mcde_pkg::OP_RECV, 48'h3, 32'h9, 8'd1, 8'd1, 48'h4, 32'h0, 8'd255, 8'd1, 1'b0};
    send_probe(p);
    // Equal id with fewer hops replaces; the min round then fills up.
    p = '{mcde_pkg::OP_RECV, 48'h5, 32'hFFFF_FFFF, 8'd0, 8'd1, 48'h6, 32'h3, 8'd200, 8'd1,
          1'b1};
    send_probe(p);
    p = '{mcde_pkg::OP_RECV, 48'h7, 32'h9, 8'd0, 8'd1, 48'h8, 32'h3, 8'd0, 8'd1, 1'b1};
    send_probe(p);
    configure(48'hA5A5_0000_5A5A, 32'h3, 5'd2, 8'd0);
    // Node id now equals a stored min id: the node elects itself.
    p = '{mcde_pkg::OP_RECV, 48'h9, 32'h1, 8'd0, 8'd0, 48'hB, 32'h3, 8'd0, 8'd0, 1'b1};
    send_probe(p);
    repeat (6) send_probe(send_item());
    configure(48'h0, 32'hFFFF_FFFF, 5'd0, 8'd255);
    p = '{mcde_pkg::OP_RECV, 48'hC, 32'h2, 8'd0, 8'd0, 48'hD, 32'h2, 8'd0, 8'd0, 1'b1};
    send_probe(p);
    repeat (3) send_probe(send_item());
  endtask

  task automatic test_random(int n);
    repeat (n) send_probe(random_item());
  endtask

  // The receiver holds off while probes keep coming, filling the block.
  task automatic test_backpressure();
    bit old_quiet;
    old_quiet = quiet;
    quiet = 1'b1;
    hold_req = 1;
    test_random(40);
    quiet = old_quiet;
  endtask

  initial begin
    own_addr_q = '0;
    own_id_q = '0;
    dist_q = mcde_pkg::DIST_RESET;
    warm_q = mcde_pkg::WARMUP_RESET;
    foreach (max_rounds[i]) max_rounds[i] = '{default: '0};
    foreach (min_rounds[i]) min_rounds[i] = '{default: '0};
    next_max_rnd = 0;
    next_min_rnd = 0;
    max_cnt = 1;
    min_cnt = 1;
    probes_sent = 0;
    head_self = 1'b1;
    head_addr_q = '0;
    head_id_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    configure(rand48(), 32'h4, 5'd2, 8'd0);
    test_random(350);
    configure(rand48(), 32'h2, 5'd4, 8'd3);
    test_random(350);
    test_backpressure();
    configure(rand48(), 32'hFFFF_FFFF, 5'd1, 8'd12);
    test_random(250);
    configure(48'hFFFF_FFFF_FFFF, 32'h0, 5'd8, 8'd1);
    test_random(300);
    configure(rand48(), 32'h5, 5'd0, 8'd0);
    test_random(150);
    configure(rand48(), 32'h1, 5'd16, 8'd5);
    test_random(120);
    configure(rand48(), 32'h6, 5'd31, 8'd255);
    test_random(60);
    configure(rand48(), $urandom, 5'd3, 8'd2);
    quiet = 1'b1;
    test_random(300);

    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  task automatic report(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
    end
  endtask

  // Result side: checks each beat and drives stall in bursts or a long hold.
  always @(posedge clk) begin
    static int burst_left = 0;
    static int hold_left = 0;
    advert_t a;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_adverts.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        a = pending_adverts.pop_front();
        report("out_max_address", a.max_addr, out_max_address);
        report("out_max_id", a.max_id, out_max_id);
        report("out_max_hops", a.max_hops, out_max_hops);
        report("out_max_round", a.max_rnd, out_max_round);
        report("out_min_address", a.min_addr, out_min_address);
        report("out_min_id", a.min_id, out_min_id);
        report("out_min_hops", a.min_hops, out_min_hops);
        report("out_min_round", a.min_rnd, out_min_round);
        report("out_min_present", a.min_pres, out_min_present);
        report("out_head_address", a.head_addr, out_head_address);
        report("out_head_id", a.head_id, out_head_id);
      end
    end
    if (hold_req != 0) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    static int quiet_cycles = 0;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
